>>> rtl/pbd_pkg.sv
// ----------------------------------------------------------------------------
// pbd_pkg
// Shared types and codes for the protobuf message decoder.
// ----------------------------------------------------------------------------
package pbd_pkg;

    typedef enum logic [3:0] {
        P_KEY   = 4'd0,
        P_VAL   = 4'd1,
        P_LEN   = 4'd2,
        P_SKIP  = 4'd3,
        P_IKEY  = 4'd4,
        P_IVAL  = 4'd5,
        P_ILEN  = 4'd6,
        P_IDATA = 4'd7,
        P_ISKIP = 4'd8,
        P_ERR   = 4'd9
    } phase_t;

    localparam logic [2:0] EV_NONE  = 3'd0;
    localparam logic [2:0] EV_TYPE  = 3'd1;
    localparam logic [2:0] EV_ROUND = 3'd2;
    localparam logic [2:0] EV_DATA  = 3'd3;
    localparam logic [2:0] EV_EMPTY = 3'd4;

    localparam logic [2:0] ERR_OK       = 3'd0;
    localparam logic [2:0] ERR_OVERFLOW = 3'd1;
    localparam logic [2:0] ERR_TRUNC    = 3'd2;
    localparam logic [2:0] ERR_WIRETYPE = 3'd3;
    localparam logic [2:0] ERR_OVERRUN  = 3'd4;

    localparam logic [2:0] FID_POINT = 3'd0;
    localparam logic [2:0] FID_E0    = 3'd1;
    localparam logic [2:0] FID_E1    = 3'd2;
    localparam logic [2:0] FID_SHARE = 3'd3;
    localparam logic [2:0] FID_ETEXT = 3'd4;
    localparam logic [2:0] NO_TARGET = 3'd7;

    localparam logic [2:0] WT_VARINT = 3'd0;
    localparam logic [2:0] WT_LEN    = 3'd2;

    localparam logic [3:0] VINT_LAST_IDX = 4'd9;

    typedef struct packed {
        logic        done;
        logic        ovf;
        logic [63:0] acc;
        logic [3:0]  shift;
    } vint_res_t;

    typedef struct packed {
        logic [2:0]  event_res;
        logic [2:0]  field_id;
        logic [63:0] value;
        logic [7:0]  data_byte;
        logic        field_start;
        logic        field_end;
        logic        message_end;
        logic [2:0]  error;
    } res_t;

endpackage

>>> rtl/pbd_varint.sv
// ----------------------------------------------------------------------------
// pbd_varint
// Folds one byte into a base-128 varint accumulator and flags completion
// or overflow.
// ----------------------------------------------------------------------------
module pbd_varint
    import pbd_pkg::*;
(
    input  logic [63:0] acc,
    input  logic [3:0]  shift,
    input  logic [7:0]  in_byte,
    output vint_res_t   res
);

    logic [3:0]  idx;
    logic [5:0]  sh_amt;
    logic [63:0] part;
    logic        cont;

    always_comb begin
        idx    = (shift > VINT_LAST_IDX) ? VINT_LAST_IDX : shift;
        sh_amt = 6'({2'b00, idx} * 6'd7);
        part   = {57'd0, in_byte[6:0]} << sh_amt;
        cont   = in_byte[7];
        res.acc   = acc | part;
        res.done  = !cont;
        res.ovf   = cont && (idx >= VINT_LAST_IDX);
        res.shift = idx + 4'd1;
    end

endmodule

>>> rtl/pbd_parser.sv
// ----------------------------------------------------------------------------
// pbd_parser
// Wire-format parser state and the per-byte decode that forms one result.
// ----------------------------------------------------------------------------
module pbd_parser
    import pbd_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       in_fire,
    input  logic [7:0] in_byte,
    input  logic       in_last,
    output logic       res_valid,
    output res_t       res
);

    phase_t      phase_reg, phase_next;
    logic        in_sub_reg, in_sub_next;
    logic [63:0] acc_reg, acc_next;
    logic [3:0]  shift_reg, shift_next;
    logic [31:0] key_reg, key_next;
    logic [2:0]  ofield_reg, ofield_next;
    logic [63:0] orem_reg, orem_next;
    logic [63:0] irem_reg, irem_next;
    logic [2:0]  target_reg, target_next;
    logic [2:0]  errc_reg, errc_next;
    logic        startp_reg, startp_next;

    vint_res_t   vr;
    logic [63:0] orem1;
    logic [63:0] irem1;
    logic [63:0] v;
    logic [2:0]  pick;

    pbd_varint u_varint (
        .acc     (acc_reg),
        .shift   (shift_reg),
        .in_byte (in_byte),
        .res     (vr)
    );

    always_comb begin
        pick = NO_TARGET;
        if ((ofield_reg == 3'd2 || ofield_reg == 3'd3) && key_reg == 32'd2) begin
            pick = FID_POINT;
        end else if (ofield_reg == 3'd4 && key_reg == 32'd2) begin
            pick = FID_E0;
        end else if (ofield_reg == 3'd4 && key_reg == 32'd3) begin
            pick = FID_E1;
        end else if (ofield_reg == 3'd5 && key_reg == 32'd1) begin
            pick = FID_SHARE;
        end else if (ofield_reg == 3'd6 && key_reg == 32'd1) begin
            pick = FID_ETEXT;
        end
    end

    always_comb begin
        phase_next  = phase_reg;
        in_sub_next = in_sub_reg;
        acc_next    = acc_reg;
        shift_next  = shift_reg;
        key_next    = key_reg;
        ofield_next = ofield_reg;
        orem_next   = orem_reg;
        irem_next   = irem_reg;
        target_next = target_reg;
        errc_next   = errc_reg;
        startp_next = startp_reg;
        res         = '0;
        v           = vr.acc;
        orem1       = (in_sub_reg && orem_reg != 64'd0) ? orem_reg - 64'd1 : orem_reg;
        irem1       = (irem_reg != 64'd0) ? irem_reg - 64'd1 : irem_reg;

        if (phase_reg != P_ERR) begin
            orem_next = orem1;
            case (phase_reg)
                P_KEY, P_IKEY, P_VAL, P_LEN, P_IVAL, P_ILEN: begin
                    acc_next   = vr.acc;
                    shift_next = vr.shift;
                    if (!vr.done && vr.ovf) begin
                        errc_next = ERR_OVERFLOW;
                        phase_next = P_ERR;
                    end else if (vr.done) begin
                        acc_next   = '0;
                        shift_next = '0;
                        case (phase_reg)
                            P_KEY, P_IKEY: begin
                                key_next = v[34:3];
                                if (v[2:0] == WT_VARINT) begin
                                    phase_next = (phase_reg == P_KEY) ? P_VAL : P_IVAL;
                                end else if (v[2:0] == WT_LEN) begin
                                    phase_next = (phase_reg == P_KEY) ? P_LEN : P_ILEN;
                                end else if (phase_reg == P_KEY) begin
                                    errc_next  = ERR_WIRETYPE;
                                    phase_next = P_ERR;
                                end
                            end
                            P_VAL: begin
                                if (key_reg == 32'd1) begin
                                    res.event_res = EV_TYPE;
                                    res.value     = v;
                                end
                                phase_next = P_KEY;
                            end
                            P_LEN: begin
                                orem_next = v;
                                if (v == 64'd0) begin
                                    phase_next = P_KEY;
                                end else if (key_reg >= 32'd2 && key_reg <= 32'd6) begin
                                    in_sub_next = 1'b1;
                                    ofield_next = key_reg[2:0];
                                    phase_next  = P_IKEY;
                                end else begin
                                    phase_next = P_SKIP;
                                end
                            end
                            P_IVAL: begin
                                if (ofield_reg <= 3'd4 && key_reg == 32'd1) begin
                                    res.event_res = EV_ROUND;
                                    res.value     = {32'd0, v[31:0]};
                                end
                                phase_next = P_IKEY;
                            end
                            default: begin
                                if (v > orem1) begin
                                    errc_next  = ERR_OVERRUN;
                                    phase_next = P_ERR;
                                end else begin
                                    target_next = pick;
                                    if (v == 64'd0) begin
                                        if (pick != NO_TARGET) begin
                                            res.event_res = EV_EMPTY;
                                            res.field_id  = pick;
                                        end
                                        phase_next = P_IKEY;
                                    end else begin
                                        irem_next   = v;
                                        startp_next = 1'b1;
                                        phase_next  = (pick != NO_TARGET) ? P_IDATA : P_ISKIP;
                                    end
                                end
                            end
                        endcase
                    end
                end
                P_SKIP: begin
                    orem_next = (orem_reg != 64'd0) ? orem_reg - 64'd1 : orem_reg;
                    if (orem_next == 64'd0) begin
                        phase_next = P_KEY;
                    end
                end
                P_IDATA, P_ISKIP: begin
                    irem_next = irem1;
                    if (phase_reg == P_IDATA) begin
                        res.event_res   = EV_DATA;
                        res.field_id    = target_reg;
                        res.data_byte   = in_byte;
                        res.field_start = startp_reg;
                        res.field_end   = (irem1 == 64'd0);
                    end
                    startp_next = 1'b0;
                    if (irem1 == 64'd0) begin
                        phase_next = P_IKEY;
                    end
                end
                default: begin
                    errc_next  = ERR_TRUNC;
                    phase_next = P_ERR;
                end
            endcase

            if (phase_next != P_ERR && in_sub_next && orem_next == 64'd0) begin
                if (phase_next == P_IKEY && shift_next == 4'd0) begin
                    in_sub_next = 1'b0;
                    phase_next  = P_KEY;
                end else begin
                    errc_next  = ERR_TRUNC;
                    phase_next = P_ERR;
                end
            end
            if (phase_next == P_ERR) begin
                res.event_res = EV_NONE;
            end
        end

        if (in_last && phase_next != P_ERR
                && !(phase_next == P_KEY && shift_next == 4'd0)) begin
            errc_next     = (phase_next == P_SKIP || in_sub_next) ? ERR_OVERRUN : ERR_TRUNC;
            phase_next    = P_ERR;
            res.event_res = EV_NONE;
        end

        res.message_end = in_last;
        res.error       = in_last ? errc_next : ERR_OK;
        res_valid       = in_fire && (in_last || res.event_res != EV_NONE);

        if (in_last) begin
            phase_next  = P_KEY;
            in_sub_next = 1'b0;
            acc_next    = '0;
            shift_next  = '0;
            key_next    = '0;
            ofield_next = '0;
            orem_next   = '0;
            irem_next   = '0;
            target_next = '0;
            errc_next   = ERR_OK;
            startp_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= P_KEY;
            in_sub_reg <= 1'b0;
            acc_reg    <= '0;
            shift_reg  <= '0;
            key_reg    <= '0;
            ofield_reg <= '0;
            orem_reg   <= '0;
            irem_reg   <= '0;
            target_reg <= '0;
            errc_reg   <= ERR_OK;
            startp_reg <= 1'b0;
        end else if (in_fire) begin
            phase_reg  <= phase_next;
            in_sub_reg <= in_sub_next;
            acc_reg    <= acc_next;
            shift_reg  <= shift_next;
            key_reg    <= key_next;
            ofield_reg <= ofield_next;
            orem_reg   <= orem_next;
            irem_reg   <= irem_next;
            target_reg <= target_next;
            errc_reg   <= errc_next;
            startp_reg <= startp_next;
        end
    end

endmodule

>>> rtl/protobuf_message_decoder.sv
// ----------------------------------------------------------------------------
// protobuf_message_decoder
// Streaming protobuf wire-format decoder for a fixed two-level schema.
//
// The slave channel takes one encoded byte per beat in s_tdata, with s_tlast
// on the final byte of a message. The master channel gives at most one
// result beat per input byte: events in m_tuser, values and the error code
// in m_tdata, and m_tlast on the result that closes a message.
// A byte enters an input register and is decoded into the output register
// once the output register is empty or its beat is being taken. One byte
// is accepted every cycle while the receiver keeps m_tready high; the
// single parser state update per byte sets this. When the receiver stalls,
// the output register holds its beat, the input register keeps its byte or
// takes one if it was empty, and s_tready then stays low until the output
// beat is taken. Reset empties both registers and returns the parser to
// the top-level key state with no error pending.
// ----------------------------------------------------------------------------
module protobuf_message_decoder
    import pbd_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // in_byte
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [79:0] m_tdata,   // value, data_byte, error, zero fill
    output logic [7:0]  m_tuser,   // event_res, field_id, field_start, field_end
    output logic        m_tlast
);

    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       in_last_reg;
    logic       out_valid_reg;
    res_t       out_reg;
    logic       proc_fire;
    logic       res_valid;
    res_t       res;

    assign proc_fire = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || proc_fire;

    pbd_parser u_parser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_fire   (proc_fire),
        .in_byte   (in_byte_reg),
        .in_last   (in_last_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (proc_fire) begin
            out_valid_reg <= res_valid;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (proc_fire && res_valid) begin
            out_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'd0, out_reg.error, out_reg.data_byte, out_reg.value};
    assign m_tuser  = {out_reg.field_end, out_reg.field_start, out_reg.field_id,
                       out_reg.event_res};
    assign m_tlast  = out_reg.message_end;

endmodule
